// ===== design/bship_pkg.sv =====
`default_nettype none

package bship_pkg;

   localparam int FRAC_BITS = 28;
   localparam int ITER_BITS = 12;

   localparam int WORD_W = 32;
   localparam int MAG_W  = 36;
   localparam int PROD_W = 2 * WORD_W;
   localparam int SQ_W   = PROD_W - FRAC_BITS;
   localparam int NEW_W  = (SQ_W + 3 > WORD_W + 2) ? SQ_W + 3 : WORD_W + 2;
   localparam int SUM_A  = (SQ_W + 1 > MAG_W + 1) ? SQ_W + 1 : MAG_W + 1;
   localparam int SUM_W  = (SUM_A > FRAC_BITS + 4) ? SUM_A : FRAC_BITS + 4;

   localparam int ESC_SCALE = 4;
   localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(ESC_SCALE) << FRAC_BITS;

   localparam int CSR_COUNT = 3;
   localparam int CSR_IDX_W = $clog2(CSR_COUNT);

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_RE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_IM    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = CSR_IDX_W'(2);

   localparam logic [ITER_BITS-1:0] ITER_LIMIT_RESET = ITER_BITS'(256);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_TEST,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_RE_RE,
      MUL_IM_IM,
      MUL_RE_IM
   } mul_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        rsp_valid;
      logic        load;
      mul_sel_type mul_sel;
      logic        cap_sq_re;
      logic        test;
      logic        update;
   } ctrl_type;

   typedef struct packed {
      logic first;
      logic over_limit;
      logic at_limit;
   } status_type;

   function automatic logic [WORD_W-1:0] abs_word(input logic signed [WORD_W-1:0] v);
      abs_word = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [NEW_W-1:0] v);
      logic [NEW_W-WORD_W:0] upper;
      upper = v[NEW_W-1:WORD_W-1];
      if ((&upper) || !(|upper)) begin
         sat_word = v[WORD_W-1:0];
      end else if (v[NEW_W-1]) begin
         sat_word = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(WORD_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/bship_if.sv =====
`default_nettype none

interface bship_req_if import bship_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] point_re;
   logic signed [WORD_W-1:0] point_im;

   modport source (output valid, output point_re, output point_im, input ready);
   modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface bship_rsp_if import bship_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     escaped;
   logic [ITER_BITS-1:0]     iter_count;
   logic signed [WORD_W-1:0] final_re;
   logic signed [WORD_W-1:0] final_im;
   logic [MAG_W-1:0]         mag_sq;

   modport source (output valid, output escaped, output iter_count, output final_re,
                   output final_im, output mag_sq, input ready);
   modport sink (input valid, input escaped, input iter_count, input final_re,
                 input final_im, input mag_sq, output ready);
endinterface

`default_nettype wire

// ===== design/burning_ship_escape_time.sv =====
// Channel  Dir  Handshake      Payload
// req_chan in   valid / ready  point_re, point_im (Q4.28)
// rsp_chan out  valid / ready  escaped, iter_count, final_re, final_im, mag_sq
// csr      in   csr_we         csr_index, csr_wdata
//
// One 32x32 multiplier is shared: re^2, im^2 and |re*im| per iteration.
// Iteration: SQ_RE, SQ_IM, TEST, UPDATE; TEST ends in DONE, left for idle on rsp ready.
// req ready only when idle; the result holds in its register until rsp ready.
// Synchronous active-high reset: sequencer idle, seeds 0, iteration limit 256.
`default_nettype none

module burning_ship_escape_time import bship_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bship_req_if.sink                 req_chan,
   bship_rsp_if.source               rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   ctrl_type   ctrl;
   status_type status;

   logic signed [WORD_W-1:0] seed_re_ff;
   logic signed [WORD_W-1:0] seed_im_ff;
   logic [ITER_BITS-1:0]     iter_limit_ff;

   logic signed [WORD_W-1:0] c_re_ff;
   logic signed [WORD_W-1:0] c_im_ff;
   logic signed [WORD_W-1:0] re_ff;
   logic signed [WORD_W-1:0] im_ff;
   logic [SQ_W-1:0]          sq_re_ff;
   logic [SQ_W-1:0]          sq_im_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [ITER_BITS-1:0]     iter_ff;
   logic                     esc_ff;
   logic                     first_ff;

   logic [PROD_W-1:0]        prod;
   logic [SQ_W-1:0]          sq_cur;
   logic [SQ_W:0]            cross_cur;
   logic [SUM_W-1:0]         mag_sum;
   logic [MAG_W-1:0]         mag_sat;
   logic [ITER_BITS:0]       iter_next;
   logic signed [NEW_W-1:0]  sq_re_ext;
   logic signed [NEW_W-1:0]  sq_im_ext;
   logic signed [NEW_W-1:0]  cross_ext;
   logic signed [NEW_W-1:0]  new_re;
   logic signed [NEW_W-1:0]  new_im;

   bship_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   bship_mul u_mul (
      .clock (clock),
      .sel   (ctrl.mul_sel),
      .re    (re_ff),
      .im    (im_ff),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_re_ff    <= '0;
         seed_im_ff    <= '0;
         iter_limit_ff <= ITER_LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_SEED_RE) begin
            seed_re_ff <= csr_wdata;
         end
         if (csr_index == CSR_SEED_IM) begin
            seed_im_ff <= csr_wdata;
         end
         if (csr_index == CSR_ITER_LIMIT) begin
            iter_limit_ff <= csr_wdata[ITER_BITS-1:0];
         end
      end
   end

   assign sq_cur    = prod[PROD_W-1:FRAC_BITS];
   assign cross_cur = prod[PROD_W-1:FRAC_BITS-1];
   assign mag_sum   = SUM_W'(sq_re_ff) + SUM_W'(sq_cur);
   assign mag_sat   = (|mag_sum[SUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];
   assign iter_next = {1'b0, iter_ff} + (ITER_BITS+1)'(1);

   assign sq_re_ext = NEW_W'(sq_re_ff);
   assign sq_im_ext = NEW_W'(sq_im_ff);
   assign cross_ext = NEW_W'(cross_cur);
   assign new_re    = sq_re_ext - sq_im_ext + NEW_W'(c_re_ff);
   assign new_im    = cross_ext + NEW_W'(c_im_ff);

   assign status.first      = first_ff;
   assign status.over_limit = mag_sum > ESC_LIMIT;
   assign status.at_limit   = first_ff ? (iter_limit_ff == '0)
                                       : (iter_next >= {1'b0, iter_limit_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         c_re_ff  <= req_chan.point_re;
         c_im_ff  <= req_chan.point_im;
         re_ff    <= seed_re_ff;
         im_ff    <= seed_im_ff;
         iter_ff  <= '0;
         esc_ff   <= 1'b0;
         first_ff <= 1'b1;
      end
      if (ctrl.cap_sq_re) begin
         sq_re_ff <= sq_cur;
      end
      if (ctrl.test) begin
         sq_im_ff <= sq_cur;
         mag_ff   <= mag_sat;
         first_ff <= 1'b0;
         if (!first_ff) begin
            if (status.over_limit) begin
               esc_ff <= 1'b1;
            end else begin
               iter_ff <= iter_next[ITER_BITS-1:0];
            end
         end
      end
      if (ctrl.update) begin
         re_ff <= sat_word(new_re);
         im_ff <= sat_word(new_im);
      end
   end

   assign req_chan.ready      = ctrl.req_ready;
   assign rsp_chan.valid      = ctrl.rsp_valid;
   assign rsp_chan.escaped    = esc_ff;
   assign rsp_chan.iter_count = iter_ff;
   assign rsp_chan.final_re   = re_ff;
   assign rsp_chan.final_im   = im_ff;
   assign rsp_chan.mag_sq     = mag_ff;

endmodule

`default_nettype wire

// ===== design/bship_mul.sv =====
`default_nettype none

module bship_mul import bship_pkg::*; (
   input  wire logic                     clock,
   input  wire mul_sel_type              sel,
   input  wire logic signed [WORD_W-1:0] re,
   input  wire logic signed [WORD_W-1:0] im,
   output logic [PROD_W-1:0]             prod
);

   logic [WORD_W-1:0] re_abs;
   logic [WORD_W-1:0] im_abs;
   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign re_abs = abs_word(re);
   assign im_abs = abs_word(im);

   always_comb begin
      unique case (sel)
         MUL_RE_RE: begin
            op_a = re_abs;
            op_b = re_abs;
         end
         MUL_IM_IM: begin
            op_a = im_abs;
            op_b = im_abs;
         end
         MUL_RE_IM: begin
            op_a = re_abs;
            op_b = im_abs;
         end
         default: begin
            op_a = re_abs;
            op_b = re_abs;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== design/bship_seq.sv =====
`default_nettype none

module bship_seq import bship_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = req_valid ? ST_SQ_RE : ST_IDLE;
         ST_SQ_RE:  state_in = ST_SQ_IM;
         ST_SQ_IM:  state_in = ST_TEST;
         ST_TEST: begin
            priority if (!status.first && status.over_limit) begin
               state_in = ST_DONE;
            end else if (status.at_limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_SQ_RE;
         ST_DONE:   state_in = rsp_ready ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MUL_RE_RE;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.load      = req_valid;
         end
         ST_SQ_RE: begin
            ctrl.mul_sel = MUL_RE_RE;
         end
         ST_SQ_IM: begin
            ctrl.mul_sel   = MUL_IM_IM;
            ctrl.cap_sq_re = 1'b1;
         end
         ST_TEST: begin
            ctrl.mul_sel = MUL_RE_IM;
            ctrl.test    = 1'b1;
         end
         ST_UPDATE: begin
            ctrl.update = 1'b1;
         end
         ST_DONE: begin
            ctrl.rsp_valid = 1'b1;
         end
         default: begin
            ctrl.mul_sel = MUL_RE_RE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/bship_checker.sv =====
`default_nettype none

module bship_checker import bship_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_escaped,
   input wire logic [ITER_BITS-1:0]     rsp_iter_count,
   input wire logic signed [WORD_W-1:0] rsp_final_re,
   input wire logic signed [WORD_W-1:0] rsp_final_im,
   input wire logic [MAG_W-1:0]         rsp_mag_sq
);

   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(ESC_LIMIT);

   // one request in flight: never ready while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result shown right after request");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("second result without a request");

   a_escape_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_escaped) |-> (rsp_mag_sq > MAG_LIMIT))
      else $error("escaped result with magnitude within limit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_escaped)
         && $stable(rsp_iter_count) && $stable(rsp_final_re)
         && $stable(rsp_final_im) && $stable(rsp_mag_sq)))
      else $error("stalled result changed");

endmodule

bind burning_ship_escape_time bship_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_escaped    (rsp_chan.escaped),
   .rsp_iter_count (rsp_chan.iter_count),
   .rsp_final_re   (rsp_chan.final_re),
   .rsp_final_im   (rsp_chan.final_im),
   .rsp_mag_sq     (rsp_chan.mag_sq)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bship_pkg::*;

   localparam int FX_ONE = 1 << FRAC_BITS;
   localparam logic signed [WORD_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] FX_MIN = 32'sh8000_0000;
   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;
   localparam longint unsigned ESCAPE_BOUND = 64'd4 << FRAC_BITS;
   localparam longint unsigned MAG_CAP = (64'd1 << MAG_W) - 64'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(CSR_COUNT);
   localparam int STALL_LIMIT = 60000;
   localparam int IDLE_GAP = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 100;
   localparam int SWEEP_PHASES = 8;
   localparam int SWEEP_POINTS = 250;

   typedef struct packed {
      logic                     escaped;
      logic [ITER_BITS-1:0]     iter_count;
      logic signed [WORD_W-1:0] final_re;
      logic signed [WORD_W-1:0] final_im;
      logic [MAG_W-1:0]         mag_sq;
   } escape_result_type;

   typedef enum int {
      RX_FREE,
      RX_HALF,
      RX_SPARSE,
      RX_MOSTLY
   } rx_mode_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   bship_req_if req_chan ();
   bship_rsp_if rsp_chan ();

   burning_ship_escape_time dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [WORD_W-1:0] seed_re_cfg;
   logic signed [WORD_W-1:0] seed_im_cfg;
   logic [ITER_BITS-1:0]     iter_limit_cfg;

   escape_result_type pending_escapes[$];
   int mismatch_count = 0;
   int burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned square_frac(input longint v);
      longint unsigned a;
      a = magnitude(v);
      return (a * a) >> FRAC_BITS;
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   function automatic escape_result_type predict_escape(input logic signed [WORD_W-1:0] c_re,
                                                        input logic signed [WORD_W-1:0] c_im);
      escape_result_type r;
      longint re, im, cre, cim, new_re, new_im;
      longint unsigned sq_re, sq_im, mag, cross_prod;
      int n;
      logic hit;
      cre = c_re;
      cim = c_im;
      re = seed_re_cfg;
      im = seed_im_cfg;
      sq_re = square_frac(re);
      sq_im = square_frac(im);
      mag = sq_re + sq_im;
      n = 0;
      hit = 1'b0;
      // the seed itself is never tested against the bound
      while (n < int'(iter_limit_cfg) && !hit) begin
         cross_prod = magnitude(re) * magnitude(im);
         new_im = longint'(cross_prod >> (FRAC_BITS - 1)) + cim;
         new_re = longint'(sq_re) - longint'(sq_im) + cre;
         im = clamp_word(new_im);
         re = clamp_word(new_re);
         sq_re = square_frac(re);
         sq_im = square_frac(im);
         mag = sq_re + sq_im;
         if (mag > ESCAPE_BOUND) begin
            hit = 1'b1;
         end else begin
            n++;
         end
      end
      r.escaped = hit;
      r.iter_count = ITER_BITS'(n);
      r.final_re = re[WORD_W-1:0];
      r.final_im = im[WORD_W-1:0];
      r.mag_sq = (mag > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : mag[MAG_W-1:0];
      return r;
   endfunction

   function automatic void note_mismatch(input string field, input longint unsigned want,
                                         input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : result_check
      escape_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_escapes.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result with none expected, iter_count %0d", $time,
                     rsp_chan.iter_count);
         end else begin
            want = pending_escapes.pop_front();
            if (rsp_chan.escaped !== want.escaped)
               note_mismatch("escaped", want.escaped, rsp_chan.escaped);
            if (rsp_chan.iter_count !== want.iter_count)
               note_mismatch("iter_count", want.iter_count, rsp_chan.iter_count);
            if (rsp_chan.final_re !== want.final_re)
               note_mismatch("final_re", want.final_re, rsp_chan.final_re);
            if (rsp_chan.final_im !== want.final_im)
               note_mismatch("final_im", want.final_im, rsp_chan.final_im);
            if (rsp_chan.mag_sq !== want.mag_sq)
               note_mismatch("mag_sq", want.mag_sq, rsp_chan.mag_sq);
         end
      end
   end

   initial begin : rsp_stall_pattern
      rx_mode_type mode;
      int span;
      rsp_chan.ready = 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 400);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               RX_FREE:   rsp_chan.ready = 1'b1;
               RX_HALF:   rsp_chan.ready = ($urandom_range(0, 1) == 1);
               RX_SPARSE: rsp_chan.ready = ($urandom_range(0, 7) == 0);
               default:   rsp_chan.ready = ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   task automatic send_point(input logic signed [WORD_W-1:0] c_re,
                             input logic signed [WORD_W-1:0] c_im);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.point_re = c_re;
      req_chan.point_im = c_im;
      do @(posedge clock); while (!req_chan.ready);
      pending_escapes.push_back(predict_escape(c_re, c_im));
   endtask

   task automatic send_random_point();
      logic signed [WORD_W-1:0] c_re, c_im;
      case ($urandom_range(0, 9))
         6, 7: begin
            c_re = $urandom;
            c_im = $urandom;
         end
         8: begin
            // just around +2 and -2 on the real axis
            c_re = ($urandom_range(0, 1) ? 2 * FX_ONE : -2 * FX_ONE) + $urandom_range(0, 255) - 128;
            c_im = $urandom_range(0, 511) - 256;
         end
         9: begin
            c_re = $urandom_range(0, FX_ONE / 8) - FX_ONE / 16;
            c_im = $urandom_range(0, FX_ONE / 8) - FX_ONE / 16;
         end
         default: begin
            c_re = $urandom_range(0, 4 * FX_ONE) - 5 * FX_ONE / 2;
            c_im = $urandom_range(0, 3 * FX_ONE) - 2 * FX_ONE;
         end
      endcase
      send_point(c_re, c_im);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SEED_RE:    seed_re_cfg = data;
         CSR_SEED_IM:    seed_im_cfg = data;
         CSR_ITER_LIMIT: iter_limit_cfg = data[ITER_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_escapes.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_point(0, 0);
      send_point(2 * FX_ONE, 0);
      send_point(-2 * FX_ONE, 0);
      send_point(FX_MAX, FX_MAX);
      send_point(FX_MIN, FX_MIN);
      send_point(FX_MIN, FX_MAX);
      send_point(-(7 * FX_ONE / 4), -(FX_ONE / 32));
   endtask

   task automatic test_zero_limit();
      settle();
      write_reg(CSR_SEED_RE, FX_MAX);
      write_reg(CSR_SEED_IM, FX_MIN);
      write_reg(CSR_ITER_LIMIT, 32'hFFFF_F000);
      send_point(0, 0);
      send_point(FX_MIN, FX_MAX);
   endtask

   task automatic test_seed_not_tested();
      settle();
      write_reg(CSR_SEED_RE, 5 * FX_ONE / 2);
      write_reg(CSR_SEED_IM, 0);
      write_reg(CSR_ITER_LIMIT, 3);
      send_point(-(25 * (FX_ONE / 4)), 0);
   endtask

   task automatic test_extreme_seeds();
      settle();
      write_reg(CSR_SEED_RE, FX_MIN);
      write_reg(CSR_SEED_IM, FX_MIN);
      write_reg(CSR_ITER_LIMIT, 1);
      write_reg(CSR_UNUSED, $urandom);
      send_point(FX_MIN, FX_MAX);
      send_point(FX_MAX, FX_MIN);
      settle();
      write_reg(CSR_SEED_RE, FX_MAX);
      write_reg(CSR_SEED_IM, FX_MAX);
      write_reg(CSR_ITER_LIMIT, 2);
      send_point(FX_MIN, FX_MIN);
   endtask

   task automatic test_long_limit();
      settle();
      write_reg(CSR_SEED_RE, 0);
      write_reg(CSR_SEED_IM, 0);
      write_reg(CSR_ITER_LIMIT, 32'h0000_0FFF);
      send_point(0, 0);
      send_point(-(7 * FX_ONE / 4), 0);
   endtask

   task automatic test_random_sweeps();
      int phase;
      logic [WORD_W-1:0] upper;
      for (phase = 0; phase < SWEEP_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 3))
            0: begin
               write_reg(CSR_SEED_RE, 0);
               write_reg(CSR_SEED_IM, 0);
            end
            1: begin
               write_reg(CSR_SEED_RE, $urandom_range(0, 2 * FX_ONE) - FX_ONE);
               write_reg(CSR_SEED_IM, $urandom_range(0, 2 * FX_ONE) - FX_ONE);
            end
            2: begin
               write_reg(CSR_SEED_RE, $urandom);
               write_reg(CSR_SEED_IM, $urandom);
            end
            default: begin
               write_reg(CSR_SEED_RE, $urandom_range(0, 1) ? FX_MAX : FX_MIN);
               write_reg(CSR_SEED_IM, $urandom_range(0, 1) ? FX_MAX : FX_MIN);
            end
         endcase
         upper = $urandom;
         write_reg(CSR_ITER_LIMIT, {upper[WORD_W-1:ITER_BITS],
                                    ITER_BITS'((phase == 0) ? 1 : $urandom_range(2, 48))});
         write_reg(CSR_UNUSED, $urandom);
         repeat (SWEEP_POINTS) send_random_point();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.point_re = '0;
      req_chan.point_im = '0;
      seed_re_cfg = '0;
      seed_im_cfg = '0;
      iter_limit_cfg = ITER_LIMIT_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_zero_limit();
      test_seed_not_tested();
      test_extreme_seeds();
      test_long_limit();
      test_random_sweeps();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_escapes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
